// ===== rtl/vtsel_pkg.sv =====
`default_nettype none

package vtsel_pkg;

    // Residues live below the modulus n+1, which is at most 1024.
    localparam int RES_W = 10;
    localparam int MOD_W = 11;
    localparam int LEN_W = 11;
    localparam int POS_W = 10;

    typedef logic [RES_W-1:0] t_res;
    typedef logic [MOD_W-1:0] t_mod;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_INSERT = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// ===== rtl/vtsel_bit_store.sv =====
`default_nettype none

module vtsel_bit_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic               o_rdata
);

    logic r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/vt_code_single_error_locator_unit.sv =====
`default_nettype none

// Varshamov-Tenengolts single-error locator.
// Input stream: one received bit per beat in s_axis_tdata[0]; s_axis_tlast marks the
// final bit of a word. Each word yields exactly one result beat on the m_axis side:
// tuser carries the correction kind, tdata carries position, inserted bit and length.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes code length n; it is
// always ready and must only be written while the block is idle.
// Flow: while loading, the block takes one bit a cycle into the bit store as the
// sender offers them, keeping the position-sum residue and ones count mod n+1 on
// the fly. After the last bit, a setup state picks the case, then the scan walks
// the store one bit a cycle, reading its registered read port, and stops on the
// first match or at the end of the word; the emit state then moves the result into
// the output register. Input is not taken during setup, scan and emit.
// The output register holds a finished result while the next word loads; if the
// receiver stalls, the block waits after its scan until that register frees up.
// Reset clears counters, handshake state and sets n to 8; the bit store is not
// cleared since only bits of the current word are ever read.
module vt_code_single_error_locator_unit #(
    parameter int MAX_WORD = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [9:0]  i_cfg_data,      // code_length
    // input bit stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [0] bit_value, [7:1] zero
    input  wire logic        s_axis_tlast,    // last_bit
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,    // [9:0] error_position, [10] inserted_bit,
                                              // [21:11] received_length, [23:22] zero
    output logic [1:0]       m_axis_tuser     // [1:0] correction_kind
);

    import vtsel_pkg::*;

    localparam int AW = $clog2(MAX_WORD);
    localparam int CW = $clog2(MAX_WORD + 2);
    localparam int KW = (CW > MOD_W) ? CW + 1 : MOD_W + 1;
    localparam logic [CW-1:0] MAXW  = CW'(MAX_WORD);
    localparam logic [CW-1:0] OVF_C = CW'(MAX_WORD + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // ---- modular helpers, operands already below m ----
    function automatic t_res inc_mod(input t_res a, input t_mod m);
        t_mod t;
        t = {1'b0, a} + MOD_W'(1);
        return (t == m) ? '0 : t[RES_W-1:0];
    endfunction

    function automatic t_res dec_mod(input t_res a, input t_mod m);
        t_mod t;
        t = m - MOD_W'(1);
        return (a == '0) ? t[RES_W-1:0] : a - RES_W'(1);
    endfunction

    function automatic t_res add_mod(input t_res a, input t_res b, input t_mod m);
        t_mod t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= m) begin
            t = t - m;
        end
        return t[RES_W-1:0];
    endfunction

    function automatic t_res sub_mod(input t_res a, input t_res b, input t_mod m);
        t_mod t;
        t = ({1'b0, a} + m) - {1'b0, b};
        return (a >= b) ? (a - b) : t[RES_W-1:0];
    endfunction

    t_state          r_state;
    logic [9:0]      r_n;
    logic [CW-1:0]   r_cnt;       // bits of the current word, OVF_C on overflow
    t_res            r_sum;       // position-sum residue
    t_res            r_ones;      // ones count residue
    t_res            r_lpos;      // (index+1) mod m of the next loaded bit
    logic [CW-1:0]   r_len;
    t_kind           r_mode;
    logic [CW-1:0]   r_i;         // scan step
    t_res            r_spos;      // (r_i+1) mod m
    t_res            r_acc;       // running residue of the scan
    logic [AW-1:0]   r_ra;        // store read address, one ahead of r_i
    t_kind           r_res_kind;
    logic [CW-1:0]   r_res_pos;
    logic            r_res_ins;
    logic            r_o_valid;
    t_kind           r_o_kind;
    logic [POS_W-1:0] r_o_pos;
    logic            r_o_ins;
    logic [LEN_W-1:0] r_o_len;

    logic            rd_bit;
    t_mod            m;
    t_res            one_mod;
    t_res            pos_cur;
    logic            accept;
    logic            cnt_full;
    logic            store_we;
    logic            ovf;
    logic [CW-1:0]   len_now;
    logic [KW-1:0]   len_k;
    logic [KW-1:0]   n_k;
    t_kind           n_mode;
    logic            b_eff;
    logic            hit;
    logic            hit_one;
    logic            last_step;
    t_res            n_acc;
    t_res            acc_inc;
    t_mod            ins_sum;
    logic            emit_go;
    logic [CW+POS_W-1:0] pos_ext;
    logic [CW+LEN_W-1:0] len_ext;

    assign m        = {1'b0, r_n} + MOD_W'(1);
    assign one_mod  = (m == MOD_W'(1)) ? '0 : RES_W'(1);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign cnt_full = (r_cnt >= MAXW);
    assign store_we = accept && !cnt_full;
    assign pos_cur  = (r_cnt == '0) ? one_mod : r_lpos;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_LOAD);

    vtsel_bit_store #(
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata[0]),
        .i_raddr (r_ra),
        .o_rdata (rd_bit)
    );

    // Pick the case from the word length.
    always_comb begin
        ovf     = (r_cnt == OVF_C);
        len_now = ovf ? MAXW : r_cnt;
        len_k   = KW'(len_now);
        n_k     = KW'(r_n);
        if (ovf) begin
            n_mode = KIND_NONE;
        end else if (len_k == n_k + KW'(1)) begin
            n_mode = KIND_DELETE;
        end else if (len_k == n_k) begin
            n_mode = KIND_CLEAR;
        end else if (len_k + KW'(1) == n_k) begin
            n_mode = KIND_INSERT;
        end else begin
            n_mode = KIND_NONE;
        end
    end

    // One scan step.
    always_comb begin
        b_eff   = (r_i == r_len) ? 1'b0 : rd_bit;
        acc_inc = inc_mod(r_acc, m);
        ins_sum = {1'b0, r_acc} + {1'b0, r_spos};
        hit_one = 1'b0;
        n_acc   = r_acc;
        case (r_mode)
            KIND_DELETE: begin
                // r_acc is (sum - ones to the right) mod m
                hit   = b_eff ? (acc_inc == r_spos) : (r_acc == '0);
                n_acc = b_eff ? acc_inc : r_acc;
            end
            KIND_CLEAR: begin
                hit = b_eff && (r_sum == r_spos);
            end
            KIND_INSERT: begin
                // r_acc is (ones to the right + sum) mod m; a 0 is tried first
                hit     = (r_acc == '0) || (ins_sum == m);
                hit_one = (r_acc != '0);
                n_acc   = b_eff ? dec_mod(r_acc, m) : r_acc;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        if (r_mode == KIND_INSERT) begin
            last_step = (r_i == r_len);
        end else begin
            last_step = (r_i + CW'(1) == r_len);
        end
    end

    assign emit_go = (r_state == ST_EMIT) && (!r_o_valid || m_axis_tready);
    assign pos_ext = {{POS_W{1'b0}}, r_res_pos};
    assign len_ext = {{LEN_W{1'b0}}, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_n       <= 10'd8;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_ones    <= '0;
            r_ra      <= '0;
            r_mode    <= KIND_NONE;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_n <= i_cfg_data;
            end
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (!cnt_full) begin
                            r_cnt  <= r_cnt + CW'(1);
                            r_lpos <= inc_mod(pos_cur, m);
                            if (s_axis_tdata[0]) begin
                                r_sum  <= add_mod(r_sum, pos_cur, m);
                                r_ones <= inc_mod(r_ones, m);
                            end
                        end else begin
                            r_cnt <= OVF_C;
                        end
                        if (s_axis_tlast) begin
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    // store read of bit 0 is issued this cycle
                    r_len  <= len_now;
                    r_mode <= n_mode;
                    r_i    <= '0;
                    r_spos <= one_mod;
                    r_ra   <= AW'(1);
                    r_acc  <= (n_mode == KIND_DELETE) ? sub_mod(r_sum, r_ones, m)
                                                      : add_mod(r_sum, r_ones, m);
                    r_res_kind <= KIND_NONE;
                    r_res_pos  <= '0;
                    r_res_ins  <= 1'b0;
                    r_state    <= (n_mode == KIND_NONE) ? ST_EMIT : ST_SCAN;
                end
                ST_SCAN: begin
                    r_i    <= r_i + CW'(1);
                    r_spos <= inc_mod(r_spos, m);
                    r_ra   <= r_ra + AW'(1);
                    r_acc  <= n_acc;
                    if (hit) begin
                        r_res_kind <= r_mode;
                        r_res_pos  <= r_i;
                        r_res_ins  <= hit_one;
                        r_state    <= ST_EMIT;
                    end else if (last_step) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_ones  <= '0;
                        r_ra    <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
            if (emit_go) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Output payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_o_kind <= r_res_kind;
            r_o_pos  <= pos_ext[POS_W-1:0];
            r_o_ins  <= r_res_ins;
            r_o_len  <= len_ext[LEN_W-1:0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {2'b00, r_o_len, r_o_ins, r_o_pos};

    // ---- assertions ----
    a_res_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ({1'b0, r_acc} < m) && ({1'b0, r_spos} < m))
        else $error("scan residue out of range");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i <= r_len) && (r_mode != KIND_NONE))
        else $error("scan ran past the word");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_kind == KIND_NONE)) |-> (r_o_pos == '0) && !r_o_ins)
        else $error("no-correction result carries a position");

    a_ins_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_ins) |-> (r_o_kind == KIND_INSERT))
        else $error("inserted bit set without insert kind");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SETUP) |-> (r_cnt != '0) && (r_cnt <= OVF_C))
        else $error("bit count out of range at end of word");

endmodule

`default_nettype wire

// ===== test/tb_vt_code_single_error_locator_unit.sv =====
`timescale 1ns / 100ps

module tb_vt_code_single_error_locator_unit;
    import vtsel_pkg::*;

    localparam int MAX_WORD    = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 8;

    // One expected correction, field for field as it leaves on the result stream.
    typedef struct packed {
        t_kind       kind;
        logic [9:0]  pos;
        logic        ins;
        logic [10:0] len;
    } t_fix;

    // One received bit as it goes out on the input stream.
    typedef struct packed {
        logic value;
        logic last;
    } t_beat;

    // Error injected into a freshly built codeword.
    typedef enum int unsigned {
        FAULT_NONE,
        FAULT_EXTRA,    // one bit too many: the block should find a bit to delete
        FAULT_RAISE,    // a zero turned into a one: the block should clear it
        FAULT_DROP      // one bit lost: the block should find where to insert
    } t_fault;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data    = 10'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;     // [0] bit_value, [7:1] zero
    logic        s_axis_tlast  = 1'b0;     // last_bit
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // [9:0] error_position, [10] inserted_bit,
                                           // [21:11] received_length, [23:22] zero
    logic [1:0]  m_axis_tuser;             // [1:0] correction_kind

    vt_code_single_error_locator_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Bits waiting to be offered, and corrections waiting to come back.
    t_beat       bit_backlog[$];
    t_fix        pending_fixes[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    // Shadow of the locator: bit store, fill level, ones seen, and the code length n.
    logic        word_bits[MAX_WORD];
    int unsigned bit_fill  = 0;
    int unsigned ones_seen = 0;
    int unsigned code_n    = 8;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or a result never shows up.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned mod_sub(int unsigned a, int unsigned b, int unsigned m);
        return (a % m + m - b % m) % m;
    endfunction

    // Scan the stored word of len bits and find the single correction, first match wins.
    function automatic t_fix locate_error(int unsigned len);
        int unsigned m;
        int unsigned sum;
        int unsigned right;
        int unsigned take;
        int unsigned base;
        int unsigned i;
        t_fix        f;
        m     = code_n + 1;
        sum   = 0;
        right = ones_seen;
        f      = '0;
        f.kind = KIND_NONE;
        f.len  = 11'(len);
        for (i = 0; i < len; i++) begin
            if (word_bits[i]) sum = (sum + i + 1) % m;
        end
        if (len == code_n + 1) begin
            // Deleting bit i removes its own position and shifts every later one down.
            for (i = 0; i < len; i++) begin
                take = 0;
                if (word_bits[i]) begin
                    right--;
                    take = i + 1;
                end
                if (mod_sub(mod_sub(sum, right, m), take, m) == 0) begin
                    f.kind = KIND_DELETE;
                    f.pos  = 10'(i);
                    return f;
                end
            end
        end else if (len == code_n) begin
            for (i = 0; i < len; i++) begin
                if (word_bits[i] && mod_sub(sum, i + 1, m) == 0) begin
                    f.kind = KIND_CLEAR;
                    f.pos  = 10'(i);
                    return f;
                end
            end
        end else if (len == code_n - 1) begin
            // Inserting before index i shifts every later one up; try a zero, then a one.
            for (i = 0; i <= len; i++) begin
                base = (right + sum) % m;
                if (base == 0) begin
                    f.kind = KIND_INSERT;
                    f.pos  = 10'(i);
                    return f;
                end
                if ((base + i + 1) % m == 0) begin
                    f.kind = KIND_INSERT;
                    f.pos  = 10'(i);
                    f.ins  = 1'b1;
                    return f;
                end
                if (i < len && word_bits[i]) right--;
            end
        end
        return f;
    endfunction

    // Take one accepted bit into the shadow; on the last bit queue the expected correction.
    function automatic void absorb_bit(t_beat b);
        t_fix f;
        if (bit_fill < MAX_WORD) begin
            word_bits[bit_fill] = b.value;
            ones_seen += b.value;
            bit_fill++;
        end else begin
            bit_fill = MAX_WORD + 1;
        end
        if (b.last) begin
            if (bit_fill > MAX_WORD) begin
                // Overlong word: extra bits were dropped and no scan is made.
                f      = '0;
                f.kind = KIND_NONE;
                f.len  = 11'(MAX_WORD);
            end else begin
                f = locate_error(bit_fill);
            end
            pending_fixes.insert(pending_fixes.size(), f);
            bit_fill  = 0;
            ones_seen = 0;
        end
    endfunction

    // Sender: offer backlog bits, hold a beat until taken, idle at random.
    always @(posedge i_clk) begin
        t_beat next_beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_bit('{value: s_axis_tdata[0], last: s_axis_tlast});
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bit_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_beat = bit_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, next_beat.value};
                    s_axis_tlast  <= next_beat.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest expectation, stall at random,
    // and on request hold off for a long stretch so the block backs up into its input.
    always @(posedge i_clk) begin
        t_fix want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_fixes.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: kind=%0d pos=%0d ins=%0d len=%0d",
                             $time, m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[10],
                             m_axis_tdata[21:11]);
                end else begin
                    want = pending_fixes.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[9:0] !== want.pos ||
                        m_axis_tdata[10] !== want.ins || m_axis_tdata[21:11] !== want.len) begin
                        error_count++;
                        $display("%0t: mismatch: expected kind=%0d pos=%0d ins=%0d len=%0d",
                                 $time, want.kind, want.pos, want.ins, want.len);
                        $display("%0t:           actual kind=%0d pos=%0d ins=%0d len=%0d",
                                 $time, m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[10],
                                 m_axis_tdata[21:11]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic void set_idling(t_idling mode);
        case (mode)
            IDLE_SENDER: begin
                tx_idle_pct  = 57;
                rx_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 57;
            end
            IDLE_BOTH: begin
                tx_idle_pct  = 10;
                rx_stall_pct = 10;
            end
            default: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endfunction

    // Queue a whole word, the final bit marked last.
    function automatic void queue_word(bit w[$]);
        int unsigned i;
        for (i = 0; i < w.size(); i++) begin
            bit_backlog.insert(bit_backlog.size(),
                               '{value: w[i], last: (i == w.size() - 1)});
        end
    endfunction

    // Random n-bit word, nudged toward a valid codeword (position sum 0 mod n+1).
    // A few words stay invalid, which is harmless extra noise.
    function automatic void make_codeword(int unsigned n, ref bit w[$]);
        int unsigned m;
        int unsigned sum;
        int unsigned tries;
        int unsigned i;
        m = n + 1;
        w.delete();
        for (i = 0; i < n; i++) w.insert(w.size(), 1'($urandom_range(1)));
        for (tries = 0; tries < 24; tries++) begin
            sum = 0;
            for (i = 0; i < n; i++) begin
                if (w[i]) sum = (sum + i + 1) % m;
            end
            if (sum == 0) break;
            if (w[sum - 1]) begin
                w[sum - 1] = 1'b0;
            end else if (!w[m - sum - 1]) begin
                w[m - sum - 1] = 1'b1;
            end else begin
                // Clearing position m-sum doubles the residue; try again from there.
                w[m - sum - 1] = 1'b0;
            end
        end
    endfunction

    function automatic void inject_fault(t_fault how, ref bit w[$]);
        int unsigned start;
        int unsigned k;
        int unsigned p;
        case (how)
            FAULT_EXTRA: w.insert($urandom_range(w.size()), 1'($urandom_range(1)));
            FAULT_DROP:  w.delete($urandom_range(w.size() - 1));
            FAULT_RAISE: begin
                start = $urandom_range(w.size() - 1);
                for (k = 0; k < w.size(); k++) begin
                    p = (start + k) % w.size();
                    if (!w[p]) begin
                        w[p] = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly codewords, most with one injected error, the rest random-length noise.
    function automatic int unsigned queue_random_word(int unsigned n);
        bit          w[$];
        int unsigned pick;
        int unsigned len;
        int unsigned i;
        pick = $urandom_range(9);
        if (pick < 8) begin
            make_codeword(n, w);
            inject_fault(t_fault'(pick % 4), w);
        end else begin
            len = $urandom_range(1, n + 3);
            if (len > MAX_WORD) len = MAX_WORD;
            for (i = 0; i < len; i++) w.insert(w.size(), 1'($urandom_range(1)));
        end
        queue_word(w);
        return w.size();
    endfunction

    // Hold off the sender until every expected correction is back and the block is quiet.
    task automatic drain_block();
        do @(negedge i_clk);
        while (bit_backlog.size() != 0 || s_axis_tvalid || pending_fixes.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_code_length(int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 10'(value);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        code_n = value;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        bit          w[$];
        int unsigned n;
        int unsigned len;
        int unsigned val;
        int unsigned ph;
        int unsigned sent;
        int unsigned i;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset length n = 8: plain codeword, all-ones short word, one error of each
        // kind, and a single-bit word of an unrelated length.
        set_idling(IDLE_NONE);
        w.delete();
        repeat (8) w.insert(w.size(), 1'b0);
        queue_word(w);
        w.delete();
        repeat (7) w.insert(w.size(), 1'b1);
        queue_word(w);
        make_codeword(8, w);
        inject_fault(FAULT_EXTRA, w);
        queue_word(w);
        make_codeword(8, w);
        inject_fault(FAULT_RAISE, w);
        queue_word(w);
        make_codeword(8, w);
        inject_fault(FAULT_DROP, w);
        queue_word(w);
        w.delete();
        w.insert(w.size(), 1'b1);
        queue_word(w);
        drain_block();

        // n = 2: every word of one to three bits.
        write_code_length(2);
        for (len = 1; len <= 3; len++) begin
            for (val = 0; val < (1 << len); val++) begin
                w.delete();
                for (i = 0; i < len; i++) w.insert(w.size(), val[i]);
                queue_word(w);
            end
        end
        drain_block();

        // Random phases, cycling the idling patterns. The first one also holds the
        // receiver off long enough for the block to back up and stall its input.
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0)      n = $urandom_range(2, 12);
            else if (ph == 5) n = $urandom_range(64, 127);
            else              n = $urandom_range(2, 40);
            write_code_length(n);
            set_idling(t_idling'(ph % 4));
            if (ph == 0) hold_request = 1'b1;
            sent = 0;
            do sent += queue_random_word(n);
            while (sent < 25 && ph != 5);
            drain_block();
        end

        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
